// File: sv/bm3_pkg.sv
// Shared types and constants for the 3x3 binary morphology block.
package bm3_pkg;

    localparam int CFG_W       = 12;  // width of the size registers
    localparam int COORD_W     = 11;  // width of out_row / out_col
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 24;

    localparam logic [CFG_W-1:0] COLS_RST = 12'd640;
    localparam logic [CFG_W-1:0] ROWS_RST = 12'd480;

    typedef enum logic [1:0] {
        CFG_IMAGE_COLS = 2'd0,
        CFG_IMAGE_ROWS = 2'd1,
        CFG_MORPH_MODE = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        MODE_ERODE  = 1'b0,
        MODE_DILATE = 1'b1
    } t_mode;

    // one window column, bit i holds row r-2+i
    typedef logic [2:0] t_wcol;

    // 3x3 window, bit i*3+j: row r-2+i, column c-j
    typedef logic [8:0] t_window;

    // results an item produces; prev_prev is bit 0 and is emitted first
    typedef struct packed {
        logic cur_cur;    // (r,   c),   closes the frame
        logic cur_prev;   // (r,   c-1), last row
        logic prev_cur;   // (r-1, c),   last column
        logic prev_prev;  // (r-1, c-1), normal lagged result
    } t_res_sel;

endpackage

// File: sv/bm3_cell.sv
// One window column cell: holds three rows of one column, shifts to its neighbor.
module bm3_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  bm3_pkg::t_wcol i_col,
    output bm3_pkg::t_wcol o_col
);

    bm3_pkg::t_wcol r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

// File: sv/bm3_line_buf.sv
// Two line stores packed as one 2-bit wide memory, registered read, same-edge bypass.
module bm3_line_buf #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [1:0]    i_wr_data,
    output logic [1:0]    o_rd_data
);

    // bit 0: row r-1, bit 1: row r-2
    logic [1:0] r_mem [DEPTH];
    logic [1:0] r_rd;
    logic [1:0] r_fwd_data;
    logic       r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    // read and write of the same entry on one edge: take the new word
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd      <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rd;

endmodule

// File: sv/bm3_emit.sv
// Result sequencer: evaluates each pending result of an item and feeds the output register.
module bm3_emit #(
    parameter int CW = 11,
    parameter int RW = 11
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  bm3_pkg::t_res_sel                 i_sel,
    input  logic [RW-1:0]                     i_row,
    input  logic [CW-1:0]                     i_col,
    input  bm3_pkg::t_window                  i_win,
    input  logic [RW-1:0]                     i_last_row,
    input  logic [CW-1:0]                     i_last_col,
    input  bm3_pkg::t_mode                    i_mode,
    input  logic                              i_ready,
    output logic                              o_free,
    output logic                              o_valid,
    output logic                              o_pixel,
    output logic [bm3_pkg::COORD_W-1:0]       o_row,
    output logic [bm3_pkg::COORD_W-1:0]       o_col,
    output logic                              o_done
);

    localparam int CWX = CW + 2;
    localparam int RWX = RW + 2;

    bm3_pkg::t_res_sel r_mask;
    logic [RW-1:0]     r_row;
    logic [CW-1:0]     r_col;

    logic              r_out_valid;
    logic              r_out_pix;
    logic [bm3_pkg::COORD_W-1:0] r_out_row;
    logic [bm3_pkg::COORD_W-1:0] r_out_col;
    logic              r_out_done;

    logic [3:0] mask_v;
    logic [3:0] sel_v;
    logic [3:0] rest_v;
    logic       sel_dr;
    logic       sel_dc;
    logic       sel_last;
    logic       out_free;
    logic       emit;
    logic [2:0] row_ok;
    logic [2:0] col_ok;
    logic       dilate;
    logic       erode;
    logic       pix;
    logic [RW-1:0] res_row;
    logic [CW-1:0] res_col;
    logic [RW+bm3_pkg::COORD_W-1:0] row_ext;
    logic [CW+bm3_pkg::COORD_W-1:0] col_ext;

    assign mask_v   = r_mask;
    assign out_free = !r_out_valid || i_ready;
    assign emit     = (mask_v != '0) && out_free;
    assign rest_v   = mask_v & ~sel_v;
    assign o_free   = (mask_v == '0) || (emit && (rest_v == '0));

    // lowest pending result first
    always_comb begin
        sel_v    = '0;
        sel_dr   = 1'b0;
        sel_dc   = 1'b0;
        sel_last = 1'b0;
        if (mask_v[0]) begin
            sel_v  = 4'b0001;
            sel_dr = 1'b1;
            sel_dc = 1'b1;
        end else if (mask_v[1]) begin
            sel_v  = 4'b0010;
            sel_dr = 1'b1;
        end else if (mask_v[2]) begin
            sel_v  = 4'b0100;
            sel_dc = 1'b1;
        end else if (mask_v[3]) begin
            sel_v    = 4'b1000;
            sel_last = 1'b1;
        end
    end

    // source cell is an interior pixel of the frame
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            row_ok[i] = ({2'b00, r_row} + RWX'(i) >= RWX'(3)) &&
                        ({2'b00, r_row} + RWX'(i) <= {2'b00, i_last_row} + RWX'(1));
        end
        for (int j = 0; j < 3; j++) begin
            col_ok[j] = ({2'b00, r_col} >= CWX'(j + 1)) &&
                        ({2'b00, r_col} + CWX'(1) <= {2'b00, i_last_col} + CWX'(j));
        end
    end

    always_comb begin
        dilate = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (i_win[i*3+j] && row_ok[i] && col_ok[j] &&
                    ((i != 0) || sel_dr) && ((j != 2) || sel_dc)) begin
                    dilate = 1'b1;
                end
            end
        end
    end

    // full neighborhood only in the window for the lagged result
    assign erode = sel_dr && sel_dc && (&i_win) &&
                   (r_row >= RW'(2)) && (r_row <= i_last_row) &&
                   (r_col >= CW'(2)) && (r_col <= i_last_col);

    assign pix     = (i_mode == bm3_pkg::MODE_DILATE) ? dilate : erode;
    assign res_row = r_row - RW'(sel_dr);
    assign res_col = r_col - CW'(sel_dc);
    assign row_ext = {{bm3_pkg::COORD_W{1'b0}}, res_row};
    assign col_ext = {{bm3_pkg::COORD_W{1'b0}}, res_col};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_mask <= i_sel;
            end else if (emit) begin
                r_mask <= bm3_pkg::t_res_sel'(rest_v);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_row <= i_row;
            r_col <= i_col;
        end
        if (emit) begin
            r_out_pix  <= pix;
            r_out_row  <= row_ext[bm3_pkg::COORD_W-1:0];
            r_out_col  <= col_ext[bm3_pkg::COORD_W-1:0];
            r_out_done <= sel_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pixel = r_out_pix;
    assign o_row   = r_out_row;
    assign o_col   = r_out_col;
    assign o_done  = r_out_done;

endmodule

// File: sv/binary_morphology_3x3.sv
// Top level of the streaming 3x3 binary erosion / dilation block.
// Binary pixels enter in raster order, one item per clock when the output side keeps up.
// An item is read against a 2-bit wide line memory (the two previous rows, MAX_COLS deep,
// one read and one write per cycle), then shifted into a chain of three column cells that
// form the 3x3 window, then handed to a result sequencer that emits one result per clock
// while the output side keeps up, through an output register. Most items give one result,
// lagging one row and one column; an item that closes a row below the first, or an item
// of the last row past column zero, gives two, and the last item of the frame gives four,
// so the input stalls while the extra results leave the single output port. An item's
// first result passes the memory stage, the sequencer load and the output register.
// Erosion sets an interior pixel whose whole neighborhood is set, border results are zero;
// dilation spreads set interior pixels by one in each direction. Size registers of zero
// act as one, sizes above MAX_COLS / MAX_ROWS saturate. The user must write configuration
// only while no item is in flight; the block itself does not enforce it. The line memory
// needs no clearing pass: entries from before the current frame never reach a result.
module binary_morphology_3x3 #(
    parameter int MAX_COLS = 2048,
    parameter int MAX_ROWS = 2048
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [1:0]                          i_cfg_index,
    input  logic [bm3_pkg::CFG_W-1:0]           i_cfg_data,
    // pixel input stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [bm3_pkg::TDATA_IN_W-1:0]      i_s_axis_tdata,   // [0] pixel_in, [7:1] zero
    // result output stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [bm3_pkg::TDATA_OUT_W-1:0]     o_m_axis_tdata,   // [0] pixel_out,
                                                                  // [11:1] out_row,
                                                                  // [22:12] out_col, [23] zero
    output logic                                o_m_axis_tlast    // frame_done
);

    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int EWC = (CW + 1 > bm3_pkg::CFG_W) ? CW + 1 : bm3_pkg::CFG_W;
    localparam int EWR = (RW + 1 > bm3_pkg::CFG_W) ? RW + 1 : bm3_pkg::CFG_W;

    // configuration registers
    logic [bm3_pkg::CFG_W-1:0] r_image_cols;
    logic [bm3_pkg::CFG_W-1:0] r_image_rows;
    bm3_pkg::t_mode            r_morph_mode;

    // effective geometry, last column / row index
    logic [EWC-1:0] cols_ext;
    logic [EWR-1:0] rows_ext;
    logic [EWC-1:0] last_col_ext;
    logic [EWR-1:0] last_row_ext;
    logic [CW-1:0]  last_col;
    logic [RW-1:0]  last_row;

    // input stage: raster position of the next item
    logic [CW-1:0] r_col_cnt;
    logic [RW-1:0] r_row_cnt;
    logic          accept;
    logic          lastc;
    logic          lastr;
    bm3_pkg::t_res_sel n_mask;

    // memory stage: item waiting for its line memory word
    logic              r_b_valid;
    logic              r_b_pix;
    logic [CW-1:0]     r_b_col;
    logic [RW-1:0]     r_b_row;
    bm3_pkg::t_res_sel r_b_mask;
    logic              b_adv;
    logic              c_free;
    logic [1:0]        line_word;

    // window cell chain
    bm3_pkg::t_wcol   w_col [4];
    bm3_pkg::t_window window;

    // result side
    logic                         out_pix;
    logic                         out_done;
    logic [bm3_pkg::COORD_W-1:0]  out_row;
    logic [bm3_pkg::COORD_W-1:0]  out_col;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_cols <= bm3_pkg::COLS_RST;
            r_image_rows <= bm3_pkg::ROWS_RST;
            r_morph_mode <= bm3_pkg::MODE_ERODE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bm3_pkg::CFG_IMAGE_COLS: begin
                    r_image_cols <= i_cfg_data;
                end
                bm3_pkg::CFG_IMAGE_ROWS: begin
                    r_image_rows <= i_cfg_data;
                end
                bm3_pkg::CFG_MORPH_MODE: begin
                    r_morph_mode <= bm3_pkg::t_mode'(i_cfg_data[0]);
                end
                default: begin
                end
            endcase
        end
    end

    // zero acts as one, oversize columns saturate at the line memory depth, rows at MAX_ROWS
    assign cols_ext = EWC'(r_image_cols);
    assign rows_ext = EWR'(r_image_rows);

    always_comb begin
        if (cols_ext == '0) begin
            last_col_ext = '0;
        end else if (cols_ext > EWC'(MAX_COLS)) begin
            last_col_ext = EWC'(MAX_COLS - 1);
        end else begin
            last_col_ext = cols_ext - EWC'(1);
        end
        if (rows_ext == '0) begin
            last_row_ext = '0;
        end else if (rows_ext > EWR'(MAX_ROWS)) begin
            last_row_ext = EWR'(MAX_ROWS - 1);
        end else begin
            last_row_ext = rows_ext - EWR'(1);
        end
    end

    assign last_col = last_col_ext[CW-1:0];
    assign last_row = last_row_ext[RW-1:0];

    // counters past a shrunk size count as last, so the frame closes there
    assign lastc = r_col_cnt >= last_col;
    assign lastr = r_row_cnt >= last_row;

    assign n_mask.prev_prev = (r_row_cnt != '0) && (r_col_cnt != '0);
    assign n_mask.prev_cur  = (r_row_cnt != '0) && lastc;
    assign n_mask.cur_prev  = lastr && (r_col_cnt != '0);
    assign n_mask.cur_cur   = lastr && lastc;

    // handshake: memory stage moves on when the sequencer can take an item
    assign b_adv           = r_b_valid && c_free;
    assign o_s_axis_tready = !r_b_valid || c_free;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
            r_b_valid <= 1'b0;
        end else begin
            if (accept) begin
                if (lastc) begin
                    r_col_cnt <= '0;
                    r_row_cnt <= lastr ? '0 : r_row_cnt + RW'(1);
                end else begin
                    r_col_cnt <= r_col_cnt + CW'(1);
                end
            end
            if (accept) begin
                r_b_valid <= 1'b1;
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_pix  <= i_s_axis_tdata[0];
            r_b_col  <= r_col_cnt;
            r_b_row  <= r_row_cnt;
            r_b_mask <= n_mask;
        end
    end

    // line word {row r-2, row r-1}; rewritten as {row r-1, new pixel}
    bm3_line_buf #(
        .DEPTH (MAX_COLS),
        .AW    (CW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_col_cnt),
        .i_wr_en   (b_adv),
        .i_wr_addr (r_b_col),
        .i_wr_data ({line_word[0], r_b_pix}),
        .o_rd_data (line_word)
    );

    // new window column: rows r-2, r-1, r from bit 0 up
    assign w_col[0] = {r_b_pix, line_word[0], line_word[1]};

    for (genvar k = 0; k < 3; k++) begin : g_cell
        bm3_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (b_adv),
            .i_col   (w_col[k]),
            .o_col   (w_col[k+1])
        );
    end

    for (genvar i = 0; i < 3; i++) begin : g_win_row
        for (genvar j = 0; j < 3; j++) begin : g_win_col
            assign window[i*3+j] = w_col[j+1][i];
        end
    end

    bm3_emit #(
        .CW (CW),
        .RW (RW)
    ) u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (b_adv),
        .i_sel      (r_b_mask),
        .i_row      (r_b_row),
        .i_col      (r_b_col),
        .i_win      (window),
        .i_last_row (last_row),
        .i_last_col (last_col),
        .i_mode     (r_morph_mode),
        .i_ready    (i_m_axis_tready),
        .o_free     (c_free),
        .o_valid    (o_m_axis_tvalid),
        .o_pixel    (out_pix),
        .o_row      (out_row),
        .o_col      (out_col),
        .o_done     (out_done)
    );

    assign o_m_axis_tdata = {1'b0, out_col, out_row, out_pix};
    assign o_m_axis_tlast = out_done;

    // a stalled memory stage keeps its item
    a_b_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && !c_free |=> r_b_valid && $stable(r_b_col) && $stable(r_b_row))
        else $error("memory stage lost or changed a stalled item");

    // column counter stays inside the line memory
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col_cnt <= CW'(MAX_COLS - 1))
        else $error("column counter beyond line memory depth");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row_cnt <= RW'(MAX_ROWS - 1))
        else $error("row counter beyond maximum frame height");

    // an item on the last column wraps to column zero
    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && lastc |=> r_col_cnt == '0)
        else $error("column counter did not wrap at end of row");

endmodule
